// ===== design/cna_pkg.sv =====
package cna_pkg;

  localparam int OW = 16;
  localparam int FRAC = OW - 3;
  localparam int AS_W = OW + 1;
  localparam int AS_SH = 16 - FRAC;
  localparam int MUL_SHIFT = 2 * FRAC - 16;
  localparam int MUL_W = 2 * OW + 1 - MUL_SHIFT;
  localparam int DEN_W = 2 * OW;
  localparam int QW = DEN_W + 17;
  localparam int DVS_W = DEN_W + 1;
  localparam int SQ_W = DEN_W + 32 - 2 * FRAC;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int CORDIC_SH = 16;
  localparam int CW = OW + CORDIC_SH + 3;
  localparam int ZW = 32;
  localparam int RES_W = 32;
  localparam int MAG_W = 31;
  localparam int ANG_W = 16;
  localparam int ANGLE_STAGES_DEF = 16;
  localparam int ATAN_N = 24;
  localparam int NCELL = QW;

  localparam logic [ZW-1:0] ATAN_LUT [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_MUL   = 3'd2,
    KIND_DIV   = 3'd3,
    KIND_POLAR = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]              kind;
    logic                    a_zero;
    logic                    den_zero;
    logic signed [AS_W-1:0]  as_re;
    logic signed [AS_W-1:0]  as_im;
    logic signed [MUL_W-1:0] mul_re;
    logic signed [MUL_W-1:0] mul_im;
    logic                    neg_re;
    logic                    neg_im;
    logic [DVS_W-1:0]        dvs;
    logic [QW-1:0]           dq_re;
    logic [QW-1:0]           dq_im;
    logic [DVS_W-1:0]        dr_re;
    logic [DVS_W-1:0]        dr_im;
    logic [SQ_W-1:0]         sq_n;
    logic [SQ_W-1:0]         sq_r;
    logic signed [CW-1:0]    cx;
    logic signed [CW-1:0]    cy;
    logic [ZW-1:0]           cz;
  } cna_data_t;

endpackage

// ===== design/cna_front.sv =====
module cna_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [2:0]                       kind_i,
  input  logic signed [cna_pkg::OW-1:0]    a_re_i,
  input  logic signed [cna_pkg::OW-1:0]    a_im_i,
  input  logic signed [cna_pkg::OW-1:0]    b_re_i,
  input  logic signed [cna_pkg::OW-1:0]    b_im_i,
  output logic                             valid_o,
  output cna_pkg::cna_data_t               data_o
);
  import cna_pkg::*;

  localparam int PW = 2 * OW;
  localparam logic signed [PW:0] MUL_RND = (PW + 1)'(1) <<< (MUL_SHIFT - 1);

  logic                   va_q, vb_q, vc_q;
  logic [2:0]             kind_a_q, kind_b_q;
  logic                   a_zero_a_q, a_zero_b_q;
  logic signed [AS_W-1:0] as_re_d, as_im_d;
  logic signed [AS_W-1:0] as_re_a_q, as_im_a_q, as_re_b_q, as_im_b_q;
  logic signed [CW-1:0]   x0, y0, cx_d, cy_d;
  logic signed [CW-1:0]   cx_a_q, cy_a_q, cx_b_q, cy_b_q;
  logic [ZW-1:0]          cz_d, cz_a_q, cz_b_q;
  logic signed [PW-1:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW-1:0]   p_br_q, p_bi_q, p_ar_q, p_ai_q;
  logic signed [PW:0]     mv_re_q, mv_im_q, nm_re_q, nm_im_q;
  logic [DEN_W-1:0]       den_q, sq_q;
  logic signed [PW:0]     mr_re, mr_im, mag_re, mag_im;
  cna_data_t              data_d, data_q;

  always_comb begin
    if (kind_i == KIND_SUB) begin
      as_re_d = {a_re_i[OW-1], a_re_i} - {b_re_i[OW-1], b_re_i};
      as_im_d = {a_im_i[OW-1], a_im_i} - {b_im_i[OW-1], b_im_i};
    end else begin
      as_re_d = {a_re_i[OW-1], a_re_i} + {b_re_i[OW-1], b_re_i};
      as_im_d = {a_im_i[OW-1], a_im_i} + {b_im_i[OW-1], b_im_i};
    end
    x0 = {{(CW-OW-CORDIC_SH){a_re_i[OW-1]}}, a_re_i, {CORDIC_SH{1'b0}}};
    y0 = {{(CW-OW-CORDIC_SH){a_im_i[OW-1]}}, a_im_i, {CORDIC_SH{1'b0}}};
    if (a_re_i[OW-1]) begin
      cx_d = -x0;
      cy_d = -y0;
      cz_d = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      cx_d = x0;
      cy_d = y0;
      cz_d = '0;
    end
  end

  always_comb begin
    mr_re  = mv_re_q + MUL_RND;
    mr_im  = mv_im_q + MUL_RND;
    mag_re = nm_re_q[PW] ? -nm_re_q : nm_re_q;
    mag_im = nm_im_q[PW] ? -nm_im_q : nm_im_q;
    data_d          = data_q;
    data_d.kind     = kind_b_q;
    data_d.a_zero   = a_zero_b_q;
    data_d.den_zero = (den_q == '0);
    data_d.as_re    = as_re_b_q;
    data_d.as_im    = as_im_b_q;
    data_d.mul_re   = mr_re[PW:MUL_SHIFT];
    data_d.mul_im   = mr_im[PW:MUL_SHIFT];
    data_d.neg_re   = nm_re_q[PW];
    data_d.neg_im   = nm_im_q[PW];
    data_d.dvs      = {den_q, 1'b0};
    data_d.dq_re    = {mag_re[PW-1:0], {(QW-PW){1'b0}}} + {{(QW-DEN_W){1'b0}}, den_q};
    data_d.dq_im    = {mag_im[PW-1:0], {(QW-PW){1'b0}}} + {{(QW-DEN_W){1'b0}}, den_q};
    data_d.dr_re    = '0;
    data_d.dr_im    = '0;
    data_d.sq_n     = {sq_q, {(SQ_W-DEN_W){1'b0}}};
    data_d.sq_r     = '0;
    data_d.cx       = cx_b_q;
    data_d.cy       = cy_b_q;
    data_d.cz       = cz_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_a_q   <= kind_i;
      a_zero_a_q <= (a_re_i == '0) && (a_im_i == '0);
      as_re_a_q  <= as_re_d;
      as_im_a_q  <= as_im_d;
      cx_a_q     <= cx_d;
      cy_a_q     <= cy_d;
      cz_a_q     <= cz_d;
      p_rr_q     <= a_re_i * b_re_i;
      p_ii_q     <= a_im_i * b_im_i;
      p_ri_q     <= a_re_i * b_im_i;
      p_ir_q     <= a_im_i * b_re_i;
      p_br_q     <= b_re_i * b_re_i;
      p_bi_q     <= b_im_i * b_im_i;
      p_ar_q     <= a_re_i * a_re_i;
      p_ai_q     <= a_im_i * a_im_i;

      kind_b_q   <= kind_a_q;
      a_zero_b_q <= a_zero_a_q;
      as_re_b_q  <= as_re_a_q;
      as_im_b_q  <= as_im_a_q;
      cx_b_q     <= cx_a_q;
      cy_b_q     <= cy_a_q;
      cz_b_q     <= cz_a_q;
      mv_re_q    <= {p_rr_q[PW-1], p_rr_q} - {p_ii_q[PW-1], p_ii_q};
      mv_im_q    <= {p_ri_q[PW-1], p_ri_q} + {p_ir_q[PW-1], p_ir_q};
      nm_re_q    <= {p_rr_q[PW-1], p_rr_q} + {p_ii_q[PW-1], p_ii_q};
      nm_im_q    <= {p_ir_q[PW-1], p_ir_q} - {p_ri_q[PW-1], p_ri_q};
      den_q      <= p_br_q + p_bi_q;
      sq_q       <= p_ar_q + p_ai_q;

      data_q     <= data_d;
    end
  end

  assign valid_o = vc_q;
  assign data_o  = data_q;

endmodule

// ===== design/cna_cell.sv =====
module cna_cell #(
  parameter int IDX          = 0,
  parameter int ANGLE_STAGES = cna_pkg::ANGLE_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cna_pkg::cna_data_t data_i,
  output logic               valid_o,
  output cna_pkg::cna_data_t data_o
);
  import cna_pkg::*;

  localparam int SQ_POS = (IDX < SQ_STEPS) ? (SQ_W - 2 - 2 * IDX) : 0;
  localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << SQ_POS;
  localparam int ATAN_IDX = (IDX < ATAN_N) ? IDX : 0;
  localparam logic [ZW-1:0] ATAN_K = ATAN_LUT[ATAN_IDX];
  localparam int CSH = (IDX < CW) ? IDX : 0;

  function automatic logic [DVS_W+QW-1:0] div_step(input logic [DVS_W-1:0] r,
                                                   input logic [QW-1:0]    n,
                                                   input logic [DVS_W-1:0] d);
    logic [DVS_W:0] t;
    logic           ge;
    t  = {r, n[QW-1]};
    ge = (t >= {1'b0, d});
    if (ge) begin
      t = t - {1'b0, d};
    end
    return {t[DVS_W-1:0], n[QW-2:0], ge};
  endfunction

  logic                 valid_q;
  cna_data_t            data_d, data_q;
  logic [SQ_W:0]        sq_sum;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    data_d = data_i;
    {data_d.dr_re, data_d.dq_re} = div_step(data_i.dr_re, data_i.dq_re, data_i.dvs);
    {data_d.dr_im, data_d.dq_im} = div_step(data_i.dr_im, data_i.dq_im, data_i.dvs);

    sq_sum = {1'b0, data_i.sq_r} + {1'b0, SQ_BIT};
    if (IDX < SQ_STEPS) begin
      if ({1'b0, data_i.sq_n} >= sq_sum) begin
        data_d.sq_n = data_i.sq_n - sq_sum[SQ_W-1:0];
        data_d.sq_r = (data_i.sq_r >> 1) + SQ_BIT;
      end else begin
        data_d.sq_r = data_i.sq_r >> 1;
      end
    end

    xs = data_i.cx;
    ys = data_i.cy;
    if (IDX < ANGLE_STAGES) begin
      if (!ys[CW-1]) begin
        data_d.cx = xs + (ys >>> CSH);
        data_d.cy = ys - (xs >>> CSH);
        data_d.cz = data_i.cz + ATAN_K;
      end else begin
        data_d.cx = xs - (ys >>> CSH);
        data_d.cy = ys + (xs >>> CSH);
        data_d.cz = data_i.cz - ATAN_K;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/complex_number_alu_core.sv =====
// Complex arithmetic unit: add, subtract, multiply and divide of two Q2.13
// complex operands with Q15.16 results, saturating in division, and the
// modulus and phase of operand A. It takes one transfer per cycle while
// stall_o is low. A result passes a front of registered products and sums,
// a chain of 49 cells and the output register. Every cell performs one
// quotient bit of the restoring divider; the first 19 also do one square root
// step and the first ANGLE_STAGES one CORDIC step. The divider's 49 quotient
// bits set the chain length. The pipeline advances in every cycle except when the
// output register holds an unaccepted result and the last cell also holds one.
module complex_number_alu_core #(
  parameter int ANGLE_STAGES = cna_pkg::ANGLE_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic [2:0]                       kind_i,
  input  logic signed [cna_pkg::OW-1:0]    a_re_i,
  input  logic signed [cna_pkg::OW-1:0]    a_im_i,
  input  logic signed [cna_pkg::OW-1:0]    b_re_i,
  input  logic signed [cna_pkg::OW-1:0]    b_im_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic signed [cna_pkg::RES_W-1:0] res_re_o,
  output logic signed [cna_pkg::RES_W-1:0] res_im_o,
  output logic [cna_pkg::MAG_W-1:0]        magnitude_o,
  output logic signed [cna_pkg::ANG_W-1:0] angle_o,
  output logic                             undefined_o,
  output logic                             saturated_o
);
  import cna_pkg::*;

  function automatic logic [RES_W:0] div_sat(input logic [QW-1:0] q, input logic neg);
    logic             big_pos;
    logic             big_neg;
    logic [RES_W-1:0] v;
    big_pos = (q[QW-1:RES_W-1] != '0);
    big_neg = (q[QW-1:RES_W] != '0) || (q[RES_W-1] && (q[RES_W-2:0] != '0));
    if (!neg) begin
      v = big_pos ? {1'b0, {(RES_W-1){1'b1}}} : q[RES_W-1:0];
    end else begin
      v = big_neg ? {1'b1, {(RES_W-1){1'b0}}} : (RES_W'(0) - q[RES_W-1:0]);
    end
    return {neg ? big_neg : big_pos, v};
  endfunction

  logic [NCELL:0]         chain_v;
  cna_data_t              chain_d [NCELL+1];
  cna_data_t              last;
  logic                   last_v;
  logic                   en;
  logic                   out_valid_q;
  logic [RES_W:0]         dre, dim;
  logic [ZW-1:0]          zsum;
  logic [RES_W-1:0]       re_d, im_d, re_q, im_q;
  logic [MAG_W-1:0]       mag_d, mag_q;
  logic [ANG_W-1:0]       ang_d, ang_q;
  logic                   undef_d, undef_q, sat_d, sat_q;

  cna_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .kind_i  (kind_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .valid_o (chain_v[0]),
    .data_o  (chain_d[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cna_cell #(
      .IDX          (g),
      .ANGLE_STAGES (ANGLE_STAGES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .data_i  (chain_d[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain_d[g+1])
    );
  end

  assign last    = chain_d[NCELL];
  assign last_v  = chain_v[NCELL];
  assign en      = !(last_v && out_valid_q && stall_i);
  assign stall_o = !en;

  always_comb begin
    re_d    = '0;
    im_d    = '0;
    mag_d   = '0;
    ang_d   = '0;
    undef_d = 1'b0;
    sat_d   = 1'b0;
    dre     = div_sat(last.dq_re, last.neg_re);
    dim     = div_sat(last.dq_im, last.neg_im);
    zsum    = last.cz + (ZW'(1) << (ZW - ANG_W - 1));
    unique case (last.kind)
      KIND_ADD, KIND_SUB: begin
        re_d = {{(RES_W-AS_W-AS_SH){last.as_re[AS_W-1]}}, last.as_re, {AS_SH{1'b0}}};
        im_d = {{(RES_W-AS_W-AS_SH){last.as_im[AS_W-1]}}, last.as_im, {AS_SH{1'b0}}};
      end
      KIND_MUL: begin
        re_d = {{(RES_W-MUL_W){last.mul_re[MUL_W-1]}}, last.mul_re};
        im_d = {{(RES_W-MUL_W){last.mul_im[MUL_W-1]}}, last.mul_im};
      end
      KIND_DIV: begin
        if (last.den_zero) begin
          undef_d = 1'b1;
        end else begin
          re_d  = dre[RES_W-1:0];
          im_d  = dim[RES_W-1:0];
          sat_d = dre[RES_W] || dim[RES_W];
        end
      end
      KIND_POLAR: begin
        if (last.a_zero) begin
          undef_d = 1'b1;
        end else begin
          mag_d = last.sq_r[MAG_W-1:0];
          ang_d = zsum[ZW-1:ZW-ANG_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && last_v) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last_v) begin
      re_q    <= re_d;
      im_q    <= im_d;
      mag_q   <= mag_d;
      ang_q   <= ang_d;
      undef_q <= undef_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o     = out_valid_q;
  assign res_re_o    = re_q;
  assign res_im_o    = im_q;
  assign magnitude_o = mag_q;
  assign angle_o     = ang_q;
  assign undefined_o = undef_q;
  assign saturated_o = sat_q;

  a_undef_not_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(undefined_o && saturated_o))
    else $error("undefined and saturated flags raised together");

  a_mag_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (magnitude_o[MAG_W-1:SQ_STEPS+1] == '0))
    else $error("modulus exceeds the square root range");

  a_last_moves_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && last_v) |=> valid_o)
    else $error("result of the last cell was lost");

  a_angle_needs_mag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !undefined_o && (magnitude_o == '0)) |-> (angle_o == '0))
    else $error("nonzero phase with zero modulus");

endmodule

// ===== tb/tb_complex_number_alu_core.sv =====
module tb_complex_number_alu_core;
  import cna_pkg::*;

  localparam int LATENCY = 53;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } op_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [30:0]        magnitude;
    logic signed [15:0] angle;
    logic               undefined;
    logic               saturated;
  } alu_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [2:0] kind_i = '0;
  logic signed [15:0] a_re_i = '0;
  logic signed [15:0] a_im_i = '0;
  logic signed [15:0] b_re_i = '0;
  logic signed [15:0] b_im_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [31:0] res_re_o;
  logic signed [31:0] res_im_o;
  logic [30:0] magnitude_o;
  logic signed [15:0] angle_o;
  logic undefined_o;
  logic saturated_o;

  op_t pending_ops[$];
  alu_res_t expected_results[$];
  int mismatch_count = 0;
  int send_idle_pct = 36;
  int recv_idle_pct = 82;
  int hold_off_cycles = 0;
  bit send_paused = 1'b0;
  longint cycle_count = 0;

  complex_number_alu_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint sat_to_32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint round_quot(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = longint'(num < 0 ? -num : num) << 16;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] phase_of(input longint x, input longint y);
    logic [31:0] z;
    longint nx;
    longint ny;
    z = 0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < ANGLE_STAGES_DEF && i < ATAN_N; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += ATAN_LUT[i];
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= ATAN_LUT[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic alu_res_t compute_alu(input op_t op);
    alu_res_t r;
    longint ar, ai, br, bi, re, im, den;
    longint unsigned sq;
    longint unsigned mag;
    logic [31:0] z;
    bit sat;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    re = 0;
    im = 0;
    sat = 1'b0;
    r = '0;
    case (op.kind)
      KIND_ADD: begin
        re = (ar + br) * 8;
        im = (ai + bi) * 8;
      end
      KIND_SUB: begin
        re = (ar - br) * 8;
        im = (ai - bi) * 8;
      end
      KIND_MUL: begin
        re = shr_floor(ar * br - ai * bi + 512, 10);
        im = shr_floor(ar * bi + ai * br + 512, 10);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.undefined = 1'b1;
        end else begin
          re = round_quot(ar * br + ai * bi, den);
          im = round_quot(ai * br - ar * bi, den);
        end
      end
      KIND_POLAR: begin
        if (ar == 0 && ai == 0) begin
          r.undefined = 1'b1;
        end else begin
          sq = longint'(ar * ar + ai * ai) << 6;
          mag = int_sqrt(sq);
          if (mag > 64'd2147483647) mag = 64'd2147483647;
          r.magnitude = mag[30:0];
          z = phase_of(ar, ai) + 32'h8000;
          r.angle = z[31:16];
        end
      end
      default: ;
    endcase
    re = sat_to_32(re, sat);
    im = sat_to_32(im, sat);
    r.res_re = re[31:0];
    r.res_im = im[31:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic queue_op(input int kind, input int ar, input int ai, input int br,
                          input int bi);
    op_t op;
    op.kind = kind[2:0];
    op.a_re = ar[15:0];
    op.a_im = ai[15:0];
    op.b_re = br[15:0];
    op.b_im = bi[15:0];
    pending_ops.push_back(op);
  endtask

  function automatic int rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return 0;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        expected_results.push_back(compute_alu({kind_i, a_re_i, a_im_i, b_re_i, b_im_i}));
      end
      if (!(valid_i && stall_o)) begin
        if (pending_ops.size() > 0 && !send_paused &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          op_t op;
          op = pending_ops.pop_front();
          valid_i <= 1'b1;
          {kind_i, a_re_i, a_im_i, b_re_i, b_im_i} <= op;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          alu_res_t e;
          e = expected_results.pop_front();
          if (res_re_o !== e.res_re) report_mismatch("res_re", res_re_o, e.res_re);
          if (res_im_o !== e.res_im) report_mismatch("res_im", res_im_o, e.res_im);
          if (magnitude_o !== e.magnitude)
            report_mismatch("magnitude", magnitude_o, e.magnitude);
          if (angle_o !== e.angle) report_mismatch("angle", angle_o, e.angle);
          if (undefined_o !== e.undefined)
            report_mismatch("undefined", undefined_o, e.undefined);
          if (saturated_o !== e.saturated)
            report_mismatch("saturated", saturated_o, e.saturated);
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        stall_i <= 1'b1;
      end else begin
        stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_op(KIND_ADD, 32767, 32767, 32767, 32767);
    queue_op(KIND_ADD, -32768, -32768, -32768, -32768);
    queue_op(KIND_SUB, 32767, -32768, -32768, 32767);
    queue_op(KIND_SUB, -32768, 0, 32767, -1);
    queue_op(KIND_MUL, -32768, -32768, -32768, -32768);
    queue_op(KIND_MUL, 32767, -32768, 32767, 32767);
    queue_op(KIND_MUL, 0, 0, 1234, -4321);
    queue_op(KIND_MUL, 1, 0, 0, 1);
    queue_op(KIND_DIV, 100, 200, 0, 0);
    queue_op(KIND_DIV, 32767, 32767, 1, 0);
    queue_op(KIND_DIV, -32768, -32768, 0, -1);
    queue_op(KIND_DIV, 8192, -8192, 8192, 8192);
    queue_op(KIND_DIV, 1, 1, 3, 0);
    queue_op(KIND_POLAR, 0, 0, 5, 5);
    queue_op(KIND_POLAR, -8192, 0, 0, 0);
    queue_op(KIND_POLAR, -32768, 0, 0, 0);
    queue_op(KIND_POLAR, 0, 32767, 0, 0);
    queue_op(KIND_POLAR, 0, -32768, 0, 0);
    queue_op(KIND_POLAR, -32768, -32768, 0, 0);
    queue_op(KIND_POLAR, 32767, -1, 0, 0);
    queue_op(5, 1000, 1000, 1000, 1000);
    queue_op(6, -1, -1, -1, -1);
    queue_op(7, 32767, -32768, 32767, -32768);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < 600; n++) begin
        k = $urandom_range(0, 15);
        queue_op(k < 14 ? k % 5 : k - 9, rand_operand(), rand_operand(),
                 rand_operand(), rand_operand());
      end
      if (phase == 2) hold_off_cycles = 300;
      wait_drained();
      send_paused = 1'b1;
      repeat (LATENCY + 10) @(posedge clk_i);
      send_paused = 1'b0;
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cna_pkg.sv
design/cna_front.sv
design/cna_cell.sv
design/complex_number_alu_core.sv
tb/tb_complex_number_alu_core.sv
